// ===== hw/rtl/msm_pkg.sv =====
// Shared constants, widths and codes for the multi-stack shared memory core.
package msm_pkg;

	// Sizing
	localparam int MEM_DEPTH  = 1024;
	localparam int MAX_STACKS = 16;
	localparam int DATA_WIDTH = 32;

	// Fixed field widths
	localparam int TOT_W   = 11;  // total_size, fill counts, segment size
	localparam int NST_W   = 5;   // num_stacks
	localparam int IDX_W   = 4;   // stack_index
	localparam int WORD_W  = 32;  // push_value / pop_value
	localparam int CFG_W   = 11;  // configuration write data
	localparam int CFG_A_W = 1;   // configuration register index

	// Derived widths
	localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int ADDR_X = (ADDR_W > TOT_W) ? ADDR_W : TOT_W;
	localparam int BASE_W = IDX_W + TOT_W;
	localparam int FILL_N = (MAX_STACKS < (1 << IDX_W)) ? MAX_STACKS : (1 << IDX_W);
	localparam int FIDX_W = (FILL_N > 1) ? $clog2(FILL_N) : 1;
	localparam int DATA_X = (DATA_WIDTH > WORD_W) ? DATA_WIDTH : WORD_W;
	localparam int DCNT_W = $clog2(TOT_W + 1);

	// Register reset values
	localparam int TOTAL_RST = 1024;
	localparam int NSTK_RST  = 1;
	localparam int SEG_RST   = ((TOTAL_RST > MEM_DEPTH) ? MEM_DEPTH : TOTAL_RST) / NSTK_RST;

	typedef enum logic [CFG_A_W-1:0] {
		REG_TOTAL_SIZE = 1'b0,
		REG_NUM_STACKS = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic {
		REQ_PUSH = 1'b0,
		REQ_POP  = 1'b1
	} req_t;

endpackage

// ===== hw/rtl/msm_ram.sv =====
// Generic single-port synchronous RAM with registered read.
module msm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                      wdata,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port, and read data held until the next read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// ===== hw/rtl/msm_div.sv =====
// Restoring divider that derives the segment size from the configuration.
module msm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [msm_pkg::TOT_W-1:0]   dividend,
	input  logic [msm_pkg::NST_W-1:0]   divisor,
	output logic                        busy,
	output logic [msm_pkg::TOT_W-1:0]   quotient
);

	logic                        busy_q;
	logic [msm_pkg::DCNT_W-1:0]  cnt_q;
	logic [msm_pkg::TOT_W-1:0]   quot_q;
	logic [msm_pkg::NST_W-1:0]   rem_q;
	logic [msm_pkg::NST_W-1:0]   div_q;
	logic [msm_pkg::NST_W:0]     rem_sh;
	logic [msm_pkg::NST_W:0]     rem_sub;
	logic                        ge;

	// One quotient bit per cycle
	always_comb begin
		rem_sh  = {rem_q, quot_q[msm_pkg::TOT_W-1]};
		rem_sub = rem_sh - {1'b0, div_q};
		ge      = (rem_sh >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			quot_q <= msm_pkg::TOT_W'(msm_pkg::SEG_RST);
			rem_q  <= '0;
			div_q  <= '0;
		end else if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			cnt_q <= msm_pkg::DCNT_W'(msm_pkg::TOT_W);
			if (divisor == '0) begin
				// no stacks: zero segment size
				quot_q <= '0;
				busy_q <= 1'b0;
			end else begin
				quot_q <= dividend;
				busy_q <= 1'b1;
			end
		end else if (busy_q) begin
			rem_q  <= ge ? rem_sub[msm_pkg::NST_W-1:0] : rem_sh[msm_pkg::NST_W-1:0];
			quot_q <= {quot_q[msm_pkg::TOT_W-2:0], ge};
			cnt_q  <= cnt_q - 1'b1;
			if (cnt_q == msm_pkg::DCNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = quot_q;

endmodule

// ===== hw/rtl/multi_stack_shared_memory_core.sv =====
// An accepted word is registered in stage one, its result in stage two. Throughput: one word
// per cycle unless out_stall or the divider holds the input; fill counts sit in flops so a
// stack can be hit back to back. The data memory has one port: each word makes at most one
// read or one write in stage one. A configuration write empties every stack and runs a
// segment-size divide, blocking input words. Reset: every stack empty, 1024 words, one stack.
module multi_stack_shared_memory_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic [msm_pkg::IDX_W-1:0]     stack_index,
	input  logic [msm_pkg::WORD_W-1:0]    push_value,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [msm_pkg::WORD_W-1:0]    pop_value,
	// configuration channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [msm_pkg::CFG_A_W-1:0]   cfg_index,
	input  logic [msm_pkg::CFG_W-1:0]     cfg_data
);

	// Configuration registers
	logic [msm_pkg::TOT_W-1:0] total_q, total_nxt, eff_total_nxt, eff_total;
	logic [msm_pkg::NST_W-1:0] nstk_q, nstk_nxt, eff_nstk_nxt, eff_nstk;
	logic                      cfg_wr, cfg_hit;
	logic                      div_busy;
	logic [msm_pkg::TOT_W-1:0] seg;

	// Pipeline control
	logic adv, acc;

	// Stage one
	logic                       valid_s1;
	msm_pkg::req_t              op_s1;
	logic [msm_pkg::IDX_W-1:0]  k_s1;
	logic [msm_pkg::WORD_W-1:0] data_s1;
	logic                       bad_s1;
	logic [msm_pkg::TOT_W-1:0]  base_s1;
	logic [msm_pkg::TOT_W-1:0]  cap_s1;

	// Stage two (output)
	logic                       valid_s2;
	msm_pkg::status_t           status_s2;
	logic                       popok_s2;

	// Fill counts
	logic [msm_pkg::TOT_W-1:0]  fill_q [msm_pkg::FILL_N];
	logic [msm_pkg::FIDX_W-1:0] fidx;
	logic [msm_pkg::TOT_W-1:0]  fill_cur;

	// Request decode at acceptance
	logic [msm_pkg::BASE_W-1:0] base_acc;
	logic [msm_pkg::TOT_W-1:0]  cap_acc;
	logic                       last_acc, bad_acc;

	// Stage one results
	msm_pkg::status_t           st_s1;
	logic                       push_ok, pop_ok;
	logic [msm_pkg::TOT_W-1:0]  addr_sum;
	logic [msm_pkg::ADDR_X-1:0] addr_x;
	logic [msm_pkg::DATA_X-1:0] wdata_x;
	logic [msm_pkg::DATA_X-1:0] rdata_x;
	logic [msm_pkg::DATA_WIDTH-1:0] ram_rdata;

	// Configuration decode and clamping
	always_comb begin
		total_nxt = total_q;
		nstk_nxt  = nstk_q;
		cfg_hit   = 1'b0;
		case (msm_pkg::cfg_reg_t'(cfg_index))
			msm_pkg::REG_TOTAL_SIZE: begin
				total_nxt = cfg_data[msm_pkg::TOT_W-1:0];
				cfg_hit   = 1'b1;
			end
			msm_pkg::REG_NUM_STACKS: begin
				nstk_nxt = cfg_data[msm_pkg::NST_W-1:0];
				cfg_hit  = 1'b1;
			end
			default: begin
				cfg_hit = 1'b0;
			end
		endcase
		cfg_wr = cfg_valid && cfg_ready && cfg_hit;
		eff_total_nxt = (32'(total_nxt) > 32'(msm_pkg::MEM_DEPTH))
			? msm_pkg::TOT_W'(msm_pkg::MEM_DEPTH) : total_nxt;
		eff_nstk_nxt  = (32'(nstk_nxt) > 32'(msm_pkg::MAX_STACKS))
			? msm_pkg::NST_W'(msm_pkg::MAX_STACKS) : nstk_nxt;
		eff_total = (32'(total_q) > 32'(msm_pkg::MEM_DEPTH))
			? msm_pkg::TOT_W'(msm_pkg::MEM_DEPTH) : total_q;
		eff_nstk  = (32'(nstk_q) > 32'(msm_pkg::MAX_STACKS))
			? msm_pkg::NST_W'(msm_pkg::MAX_STACKS) : nstk_q;
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= msm_pkg::TOT_W'(msm_pkg::TOTAL_RST);
			nstk_q  <= msm_pkg::NST_W'(msm_pkg::NSTK_RST);
		end else if (cfg_wr) begin
			total_q <= total_nxt;
			nstk_q  <= nstk_nxt;
		end
	end

	// Segment size divider, restarted by every register write
	msm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cfg_wr),
		.dividend (eff_total_nxt),
		.divisor  (eff_nstk_nxt),
		.busy     (div_busy),
		.quotient (seg)
	);

	// Handshake: whole pipe moves when the output register is free or drained
	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = !adv || div_busy;
	assign acc      = in_valid && !in_stall;

	// Segment base and capacity of the addressed stack
	always_comb begin
		bad_acc  = ({1'b0, stack_index} >= eff_nstk);
		last_acc = (({1'b0, stack_index} + 1'b1) == eff_nstk);
		base_acc = msm_pkg::BASE_W'(stack_index) * msm_pkg::BASE_W'(seg);
		cap_acc  = last_acc ? (eff_total - base_acc[msm_pkg::TOT_W-1:0]) : seg;
	end

	// Stage one register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && acc) begin
			op_s1   <= msm_pkg::req_t'(req_type);
			k_s1    <= stack_index;
			data_s1 <= push_value;
			bad_s1  <= bad_acc;
			base_s1 <= base_acc[msm_pkg::TOT_W-1:0];
			cap_s1  <= cap_acc;
		end
	end

	// Fill check and memory address
	always_comb begin
		fidx     = k_s1[msm_pkg::FIDX_W-1:0];
		fill_cur = fill_q[fidx];
		push_ok  = 1'b0;
		pop_ok   = 1'b0;
		st_s1    = msm_pkg::ST_OK;
		if (bad_s1) begin
			st_s1 = msm_pkg::ST_BAD_INDEX;
		end else if (op_s1 == msm_pkg::REQ_PUSH) begin
			if (fill_cur >= cap_s1) begin
				st_s1 = msm_pkg::ST_FULL;
			end else begin
				push_ok = 1'b1;
			end
		end else begin
			if (fill_cur == '0) begin
				st_s1 = msm_pkg::ST_EMPTY;
			end else begin
				pop_ok = 1'b1;
			end
		end
		addr_sum = base_s1 + fill_cur - (pop_ok ? msm_pkg::TOT_W'(1) : msm_pkg::TOT_W'(0));
		addr_x   = msm_pkg::ADDR_X'(addr_sum);
		wdata_x  = msm_pkg::DATA_X'(data_s1);
	end

	// Fill counts: cleared by reset and by any register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < msm_pkg::FILL_N; i++) begin
				fill_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			for (int i = 0; i < msm_pkg::FILL_N; i++) begin
				fill_q[i] <= '0;
			end
		end else if (adv && valid_s1) begin
			if (push_ok) begin
				fill_q[fidx] <= fill_cur + 1'b1;
			end else if (pop_ok) begin
				fill_q[fidx] <= fill_cur - 1'b1;
			end
		end
	end

	// Shared data memory
	msm_ram #(
		.WIDTH (msm_pkg::DATA_WIDTH),
		.DEPTH (msm_pkg::MEM_DEPTH)
	) u_data_ram (
		.clk   (clk),
		.we    (adv && valid_s1 && push_ok),
		.re    (adv && valid_s1 && pop_ok),
		.addr  (addr_x[msm_pkg::ADDR_W-1:0]),
		.wdata (wdata_x[msm_pkg::DATA_WIDTH-1:0]),
		.rdata (ram_rdata)
	);

	// Stage two: result word; popped data comes straight from the RAM read register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			status_s2 <= st_s1;
			popok_s2  <= pop_ok;
		end
	end

	assign rdata_x   = msm_pkg::DATA_X'(ram_rdata);
	assign out_valid = valid_s2;
	assign status    = status_s2;
	assign pop_value = popok_s2 ? rdata_x[msm_pkg::WORD_W-1:0] : '0;

endmodule
